// File: rtl/core/impm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// impm_pkg
// Shared constants and types of the image MSE and PSNR meter.
// ----------------------------------------------------------------------------
package impm_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 4194304;
  localparam logic [7:0]  OFFSET_RESET   = 8'd40;
  localparam logic [13:0] PSNR_ZERO_MSE  = 14'd9999;
  localparam logic [13:0] PSNR_CAP       = 14'd12000;
  localparam logic [16:0] PEAK_SQ        = 17'd65025;
  localparam logic [28:0] LOG10_2_Q20    = 29'd315652829;

  // Sum of squares width: enough for 2^24 pixels of 255^2
  localparam int SUM_W = 40;
  localparam int Q_W   = 48;    // shifted sum and 65025*count

  // Frame totals handed from the accumulator to the metric unit
  typedef struct packed {
    logic [SUM_W-1:0] sum_t;
    logic [SUM_W-1:0] sum_b;
    logic [24:0]      count;
  } impm_frame_t;

endpackage : impm_pkg
`default_nettype wire

// File: rtl/core/image_mse_psnr_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_mse_psnr_meter
// Per-pixel brightening with frame-level MSE and PSNR of a luma pair stream.
// ----------------------------------------------------------------------------
// Usage: send (reference, test) pixel pairs on the in_ channel, tlast on the
// final pixel of a frame. Every request yields one out_ request carrying the
// brightened pixel; the request for the last pixel also carries both MSEs
// (Q16.8) and both PSNRs (hundredths of a dB) with tuser set.
// The front end accumulates at one pixel a cycle, while the queue has room,
// into a four-entry queue. The back end delivers an ordinary pixel through
// its output state; a frame end first runs the bit-serial divider and the
// shared squaring log2 unit for both MSEs and both PSNRs. The back end takes
// no new queue entry until its last result has been delivered; the input
// stalls only when the queue fills.
// cfg_ writes the brightness offset (reset value 40); write only when idle.
// Reset clears the sums, the count, the queue and the output valid flag.
// When out_tready is low the result holds and the queue absorbs pixels.
// ----------------------------------------------------------------------------
module image_mse_psnr_meter
  import impm_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // reference_pixel, test_pixel
  input  wire logic        in_tlast,   // last_pixel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // brightened_pixel, mse_test,
                                       // mse_brightened, psnr_test,
                                       // psnr_brightened, zero fill
  output logic             out_tuser   // frame_done
);

  localparam int QW = 8 + 1 + $bits(impm_frame_t);

  logic [7:0]  offset_r;
  logic        q_full, q_empty, q_push, q_pop, f_last;
  logic [7:0]  f_bright;
  impm_frame_t f_frame, b_frame;
  logic [QW-1:0] q_out;
  logic [7:0]  o_bright;
  logic [23:0] o_mse_t, o_mse_b;
  logic [13:0] o_psnr_t, o_psnr_b;

  assign cfg_ready = 1'b1;

  // Hold the brightness offset
  always_ff @(posedge clk) begin
    if (!rst_n) offset_r <= OFFSET_RESET;
    else if (cfg_valid) offset_r <= cfg_data;
  end

  impm_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
    .clk, .rst_n, .offset(offset_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .ref_px(in_tdata[7:0]), .test_px(in_tdata[15:8]), .last_px(in_tlast),
    .q_full, .q_push, .q_bright(f_bright), .q_last(f_last), .q_frame(f_frame)
  );

  impm_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk, .rst_n, .push(q_push), .push_data({f_bright, f_last, f_frame}),
    .full(q_full), .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  assign b_frame = q_out[$bits(impm_frame_t)-1:0];

  impm_back u_back (
    .clk, .rst_n, .q_empty, .q_bright(q_out[QW-1 -: 8]),
    .q_last(q_out[QW-9]), .q_frame(b_frame), .q_pop,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .o_bright, .o_done(out_tuser), .o_mse_t, .o_mse_b, .o_psnr_t, .o_psnr_b
  );

  assign out_tdata = {4'd0, o_psnr_b, o_psnr_t, o_mse_b, o_mse_t, o_bright};

endmodule : image_mse_psnr_meter
`default_nettype wire

// File: rtl/core/impm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// impm_front
// Brightens each pixel, accumulates squared differences and counts pixels.
// Pushes one queue entry per pixel; the last pixel carries frame totals.
// ----------------------------------------------------------------------------
module impm_front
  import impm_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  offset,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  ref_px,
  input  wire logic [7:0]  test_px,
  input  wire logic        last_px,
  input  wire logic        q_full,
  output logic             q_push,
  output logic [7:0]       q_bright,
  output logic             q_last,
  output impm_frame_t      q_frame
);

  logic [SUM_W-1:0] sum_t_r, sum_t_nxt, sum_b_r, sum_b_nxt;
  logic [24:0]      cnt_r, cnt_nxt;
  logic [8:0]       bsum;
  logic [7:0]       bright;
  logic [7:0]       d1, d2;
  logic             take;

  // Saturating brightness add
  assign bsum   = {1'b0, test_px} + {1'b0, offset};
  assign bright = bsum[8] ? 8'hFF : bsum[7:0];
  assign d1     = (ref_px > test_px) ? ref_px - test_px : test_px - ref_px;
  assign d2     = (ref_px > bright) ? ref_px - bright : bright - ref_px;
  assign take   = cnt_r < 25'(MAX_PIXELS);

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    sum_t_nxt = sum_t_r;
    sum_b_nxt = sum_b_r;
    cnt_nxt   = cnt_r;
    if (take) begin
      sum_t_nxt = sum_t_r + SUM_W'(16'(d1) * 16'(d1));
      sum_b_nxt = sum_b_r + SUM_W'(16'(d2) * 16'(d2));
      cnt_nxt   = cnt_r + 25'd1;
    end
  end

  assign q_bright      = bright;
  assign q_last        = last_px;
  assign q_frame.sum_t = sum_t_nxt;
  assign q_frame.sum_b = sum_b_nxt;
  assign q_frame.count = cnt_nxt;

  // Advance accumulators, clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_t_r <= '0;
      sum_b_r <= '0;
      cnt_r   <= '0;
    end else if (q_push) begin
      if (last_px) begin
        sum_t_r <= '0;
        sum_b_r <= '0;
        cnt_r   <= '0;
      end else begin
        sum_t_r <= sum_t_nxt;
        sum_b_r <= sum_b_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 25'(MAX_PIXELS)) else $error("pixel count beyond cap");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && last_px |=> cnt_r == '0) else $error("count not cleared");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !q_push |=> $stable(cnt_r)) else $error("count moved without request");
`endif

endmodule : impm_front
`default_nettype wire

// File: rtl/core/impm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// impm_queue
// Short FIFO between the accumulator front and the metric back end.
// ----------------------------------------------------------------------------
module impm_queue
  import impm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign full     = cnt_r == (AW+1)'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem[rp_r];

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from empty queue");
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule : impm_queue
`default_nettype wire

// File: rtl/core/impm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// impm_back
// Pops queue entries and drives results. Frame-end entries run a serial
// divider for both MSEs and a squaring log2 unit for both PSNRs.
// ----------------------------------------------------------------------------
module impm_back
  import impm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire logic [7:0]  q_bright,
  input  wire logic        q_last,
  input  wire impm_frame_t q_frame,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       o_bright,
  output logic             o_done,
  output logic [23:0]      o_mse_t,
  output logic [23:0]      o_mse_b,
  output logic [13:0]      o_psnr_t,
  output logic [13:0]      o_psnr_b
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_LNORM, S_LSQ, S_LMUL, S_LSEL, S_PMUL, S_PRND, S_OUT
  } state_t;

  state_t           st_r;
  impm_frame_t      fr_r;
  logic [7:0]       bright_r;
  logic             done_r;
  logic [Q_W-1:0]   rem_r;
  logic [Q_W-1:0]   quo_r;
  logic [Q_W-1:0]   dvd_r;
  logic [5:0]       bit_r;
  logic             which_r;       // 0 test, 1 brightened
  logic [23:0]      mse_t_r, mse_b_r;
  logic [13:0]      psnr_t_r, psnr_b_r;
  logic             lsel_r;        // 0 numerator log, 1 denominator log
  logic [Q_W-1:0]   lv_r;
  logic [31:0]      ly_r;
  logic [63:0]      lsq_r;
  logic [4:0]       li_r;
  logic [25:0]      lr_r;
  logic [25:0]      ln_r;
  logic [25:0]      d_r;
  logic [54:0]      pm_r;
  logic [5:0]       msb;
  logic [SUM_W-1:0] cur_sum;
  logic [Q_W-1:0]   rem_sh;
  logic [Q_W-1:0]   num_v;
  logic [31:0]      y_sq;
  logic [13:0]      psnr_v;
  logic [40:0]      pround;

  assign cur_sum = which_r ? fr_r.sum_b : fr_r.sum_t;
  assign num_v   = Q_W'(fr_r.count) * Q_W'(PEAK_SQ);
  assign rem_sh  = {rem_r[Q_W-2:0], dvd_r[bit_r]};
  assign y_sq    = lsq_r[61:30];
  assign pround  = 41'((pm_r + (55'd1 << 39)) >> 40);
  assign psnr_v  = (pround > 41'(PSNR_CAP)) ? PSNR_CAP : pround[13:0];

  // Leading one position of the log operand
  always_comb begin
    msb = '0;
    for (int i = 0; i < Q_W; i++) begin
      if (lv_r[i]) msb = 6'(i);
    end
  end

  assign q_pop = (st_r == S_IDLE) && !q_empty;

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            bright_r <= q_bright;
            done_r   <= q_last;
            fr_r     <= q_frame;
            mse_t_r  <= '0;
            mse_b_r  <= '0;
            psnr_t_r <= '0;
            psnr_b_r <= '0;
            which_r  <= 1'b0;
            if (q_last) begin
              rem_r <= '0;
              quo_r <= '0;
              dvd_r <= {q_frame.sum_t, 8'd0};
              bit_r <= 6'(Q_W-1);
              st_r  <= S_DIV;
            end else begin
              st_r  <= S_OUT;
            end
          end
        end
        // Restoring division, one quotient bit a cycle
        S_DIV: begin
          if (rem_sh >= Q_W'(fr_r.count)) begin
            rem_r <= rem_sh - Q_W'(fr_r.count);
            quo_r <= {quo_r[Q_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[Q_W-2:0], 1'b0};
          end
          if (bit_r == '0) begin
            lsel_r <= 1'b0;
            lv_r   <= num_v;
            st_r   <= S_LNORM;
          end
          bit_r <= bit_r - 6'd1;
        end
        // Latch the MSE and scale the log operand to Q1.30
        S_LNORM: begin
          if (!which_r) mse_t_r <= quo_r[23:0];
          else          mse_b_r <= quo_r[23:0];
          if (msb > 6'd30) ly_r <= 32'(lv_r >> (msb - 6'd30));
          else             ly_r <= 32'(lv_r << (6'd30 - msb));
          lr_r <= 26'({msb, 20'd0});
          li_r <= 5'd19;
          st_r <= S_LSQ;
        end
        S_LSQ: begin
          lsq_r <= ly_r * ly_r;
          st_r  <= S_LSEL;
        end
        S_LSEL: begin
          if (y_sq[31]) begin
            ly_r <= {1'b0, y_sq[31:1]};
            lr_r[li_r] <= 1'b1;
          end else begin
            ly_r <= y_sq;
          end
          if (li_r == '0) st_r <= S_LMUL;
          else begin
            li_r <= li_r - 5'd1;
            st_r <= S_LSQ;
          end
        end
        // One log done: move on to the other or subtract
        S_LMUL: begin
          if (!lsel_r) begin
            ln_r   <= lr_r;
            lsel_r <= 1'b1;
            lv_r   <= Q_W'(cur_sum);
            st_r   <= S_LNORM;
          end else begin
            d_r  <= (ln_r > lr_r) ? ln_r - lr_r : '0;
            st_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          pm_r <= 55'(d_r) * 55'(LOG10_2_Q20);
          st_r <= S_PRND;
        end
        S_PRND: begin
          if (!which_r) psnr_t_r <= (cur_sum == '0) ? PSNR_ZERO_MSE : psnr_v;
          else          psnr_b_r <= (cur_sum == '0) ? PSNR_ZERO_MSE : psnr_v;
          if (!which_r) begin
            which_r <= 1'b1;
            rem_r   <= '0;
            quo_r   <= '0;
            dvd_r   <= {fr_r.sum_b, 8'd0};
            bit_r   <= 6'(Q_W-1);
            st_r    <= S_DIV;
          end else begin
            out_valid <= 1'b1;
            st_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            st_r      <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // S_LNORM keeps its mse capture; the log operand path stays unaffected
  assign o_bright = bright_r;
  assign o_done   = done_r;
  assign o_mse_t  = mse_t_r;
  assign o_mse_b  = mse_b_r;
  assign o_psnr_t = psnr_t_r;
  assign o_psnr_b = psnr_b_r;

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_valid) else $error("pop while result pending");
  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_OUT) else $error("result outside output state");
  a_nondone_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !o_done |-> o_mse_t == '0 && o_psnr_b == '0)
    else $error("metrics on non-final pixel");
`endif

endmodule : impm_back
`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the image MSE and PSNR meter: directed and random
// pixel frames under several idle/stall patterns, scored against a predictor.
// ----------------------------------------------------------------------------

class psnr_scoreboard;
  logic [7:0]  offset;
  logic [63:0] sum_t, sum_b, count;
  logic [87:0]  exp_data[$];
  logic         exp_user[$];
  int unsigned  mismatches;
  int unsigned  frames;

  function new();
    offset = impm_pkg::OFFSET_RESET;
    sum_t = 0; sum_b = 0; count = 0;
    mismatches = 0; frames = 0;
  endfunction

  // log2 in unsigned Q.20, squaring method
  function automatic logic [63:0] log2_q20(logic [63:0] v);
    int unsigned e;
    logic [63:0] t, y, r;
    e = 0; t = v;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    if (e > 30) y = v >> (e - 30);
    else y = v << (30 - e);
    r = 64'(e) << 20;
    for (int i = 19; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [13:0] psnr(logic [63:0] s, logic [63:0] c);
    logic [63:0] ln, ld, d, p;
    if (s == 0) return impm_pkg::PSNR_ZERO_MSE;
    ln = log2_q20(64'd65025 * c);
    ld = log2_q20(s);
    d = (ln > ld) ? ln - ld : 64'd0;
    p = (d * 64'd315652829 + (64'd1 << 39)) >> 40;
    if (p > 12000) p = 12000;
    return p[13:0];
  endfunction

  function automatic logic [23:0] mse(logic [63:0] s, logic [63:0] c);
    logic [63:0] m;
    if (c == 0) return 24'd0;
    m = (s << 8) / c;
    return m[23:0];
  endfunction

  // Predict the result of one accepted pixel request
  function void note_pixel(logic [7:0] rp, logic [7:0] tp, logic last);
    logic [8:0] b;
    logic [63:0] d1, d2;
    logic [87:0] dat;
    b = tp + offset;
    if (b > 255) b = 255;
    if (count < impm_pkg::MAX_PIXELS_DEF) begin
      d1 = (rp > tp) ? rp - tp : tp - rp;
      d2 = (rp > b) ? rp - b : b - rp;
      sum_t += d1 * d1;
      sum_b += d2 * d2;
      count++;
    end
    dat = '0;
    dat[7:0] = b[7:0];
    if (last) begin
      dat[31:8]  = mse(sum_t, count);
      dat[55:32] = mse(sum_b, count);
      dat[69:56] = psnr(sum_t, count);
      dat[83:70] = psnr(sum_b, count);
      sum_t = 0; sum_b = 0; count = 0;
      frames++;
    end
    exp_data.push_back(dat);
    exp_user.push_back(last);
  endfunction

  function void check_result(logic [87:0] dat, logic user);
    logic [87:0] e;
    logic eu;
    if (exp_data.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result data=%h user=%b", dat, user);
      return;
    end
    e = exp_data.pop_front();
    eu = exp_user.pop_front();
    if (e !== dat || eu !== user) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: exp bp=%0d mt=%0d mb=%0d pt=%0d pb=%0d u=%b",
                  " | got bp=%0d mt=%0d mb=%0d pt=%0d pb=%0d u=%b"},
                 e[7:0], e[31:8], e[55:32], e[69:56], e[83:70], eu,
                 dat[7:0], dat[31:8], dat[55:32], dat[69:56], dat[83:70], user);
    end
  endfunction
endclass

module tb_top;
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic         out_tuser;

  psnr_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned pixels_sent = 0;

  image_mse_psnr_meter dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  // Check results at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one pixel request, with optional idle cycles first
  task automatic send_pixel(logic [7:0] rp, logic [7:0] tp, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tp, rp};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(rp, tp, last);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.exp_data.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_offset(logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.offset = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random frame: mostly short, with random pixel content
  task automatic random_frame(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      logic [7:0] rp, tp;
      rp = 8'($urandom_range(255));
      case ($urandom_range(3))
        0: tp = rp;
        1: tp = 8'(rp + $urandom_range(7) - 3);
        default: tp = 8'($urandom_range(255));
      endcase
      send_pixel(rp, tp, i == len - 1);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes with reset offset
    send_pixel(8'd0, 8'd0, 1'b1);          // zero MSE on the test pixel
    send_pixel(8'd255, 8'd0, 1'b1);        // largest error
    send_pixel(8'd0, 8'd255, 1'b0);        // saturation
    send_pixel(8'd255, 8'd255, 1'b1);
    send_pixel(8'd100, 8'd101, 1'b0);      // tiny error gives a fractional MSE
    for (int i = 0; i < 6; i++) send_pixel(8'd100, 8'd100, 1'b0);
    send_pixel(8'd100, 8'd100, 1'b1);
    write_offset(8'd0);
    send_pixel(8'd77, 8'd77, 1'b1);
    send_pixel(8'd170, 8'd85, 1'b1);
    write_offset(8'd255);
    send_pixel(8'd255, 8'd1, 1'b0);
    send_pixel(8'd0, 8'd0, 1'b1);

    // Random phases over offsets and idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      write_offset(ph == 0 ? 8'd40 : 8'($urandom_range(255)));
      if (ph == 2) hold_off_cycles = 300;   // back up the queue
      while (pixels_sent < 25 + (ph + 1) * 100)
        random_frame($urandom_range(9) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 8));
    end
    send_idle_pct = 0; stall_pct = 0;
    drain();
    repeat (300) @(negedge clk);
    $display("Covered %0d pixels in %0d frames across four idle/stall phases.",
             pixels_sent, sb.frames);
    if (sb.mismatches == 0 && sb.exp_data.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d left over", sb.mismatches, sb.exp_data.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end
endmodule
